/* sv/rtd_code_to_temperature_macros.svh */
// Assertion shorthands used by the checker module.
`ifndef RTD_CODE_TO_TEMPERATURE_MACROS_SVH
`define RTD_CODE_TO_TEMPERATURE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RTD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtd port check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtd port check failed");

`endif

/* sv/rtdct_pkg.sv */
package rtdct_pkg;

  localparam int ADC_W     = 15;
  localparam int SCALE_W   = 31;
  localparam int LIMIT_W   = 7;
  localparam int TOL_W     = 16;
  localparam int TEMP_W    = 19;
  localparam int CFG_IDX_W = 2;
  localparam int RR_W      = 46;
  localparam int DIVD_W    = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 2'd0,
    REG_LIMIT = 2'd1,
    REG_TOL   = 2'd2
  } reg_idx_t;

  localparam logic [SCALE_W-1:0] SCALE_RST = 31'd134217728;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd20;
  localparam logic [TOL_W-1:0]   TOL_RST   = 16'd3;
  localparam logic [LIMIT_W-1:0] MAX_STEPS = 7'd64;

  // Callendar-Van Dusen constants in fixed point
  localparam logic signed [63:0] A_Q36      = 64'sd268576331;
  localparam logic signed [63:0] A2_Q72     = 64'sd72133203552537257;
  localparam logic signed [63:0] FOURB_Q72  = 64'sd10908666575428880;
  localparam logic signed [63:0] K_EST      = 64'sd865801;
  localparam logic signed [63:0] COEF_A_Q60 = 64'sd4505963116454940;
  localparam logic signed [63:0] COEF_B_Q60 = -64'sd665812168910;
  localparam logic signed [63:0] COEF_C_Q60 = -64'sd4822671;
  localparam logic signed [63:0] T100_Q16   = 64'sd6553600;
  localparam logic signed [63:0] T75_Q16    = 64'sd4915200;
  localparam logic signed [63:0] T_LIMIT    = 64'sd33554432;
  localparam logic signed [31:0] T_HOT      = 32'sd65536000;

  localparam logic signed [TEMP_W-1:0] OUT_HOT  = 19'sd256000;
  localparam logic signed [TEMP_W-1:0] OUT_COLD = -19'sd65536;

  // request to the shared multiply-shift unit
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         shift;
  } mul_req_t;

endpackage

/* sv/rtdct_mul.sv */
module rtdct_mul (
  input  logic                clk,
  input  logic                rst,
  input  rtdct_pkg::mul_req_t req,
  output logic                done,
  output logic signed [63:0]  p
);
  import rtdct_pkg::*;

  logic [63:0]  ma, mb;
  logic         neg;
  logic [5:0]   sh;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh, acc_sh;
  logic [62:0]  mag;

  // one 32x32 partial product per cycle, low halves first
  always_comb begin
    ah     = cnt[0] ? ma[63:32] : ma[31:0];
    bh     = cnt[1] ? mb[63:32] : mb[31:0];
    pp     = ah * bh;
    pp_sh  = {64'd0, pp} << {cnt[0] & cnt[1], cnt[0] ^ cnt[1], 5'd0};
    acc_sh = acc >> sh;
    mag    = acc_sh[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ma   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        mb   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        neg  <= req.a[63] ^ req.b[63];
        sh   <= req.shift;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt[2]) begin
          p    <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          acc <= acc + pp_sh;
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule

/* sv/rtdct_sqrt.sv */
module rtdct_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] v,
  output logic        done,
  output logic [31:0] root
);
  import rtdct_pkg::*;

  logic [62:0] rem, res, b, trial;
  logic [4:0]  k;
  logic        busy;
  logic        ge;

  always_comb begin
    b     = 63'd1 << {k, 1'b0};
    trial = res + b;
    ge    = rem >= trial;
  end

  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= v;
        res  <= '0;
        k    <= 5'd31;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - trial;
          res <= (res >> 1) + b;
        end else begin
          res <= res >> 1;
        end
        if (k == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 5'd1;
        end
      end
    end
  end

endmodule

/* sv/rtdct_div.sv */
module rtdct_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [rtdct_pkg::DIVD_W-1:0]       dividend,
  input  logic [63:0]                        divisor,
  output logic                               done,
  output logic [rtdct_pkg::DIVD_W-1:0]       quot
);
  import rtdct_pkg::*;

  logic [63:0]       rem, d;
  logic [64:0]       rsh;
  logic [DIVD_W-1:0] q;
  logic [5:0]        cnt;
  logic              busy;

  assign rsh  = {rem, q[DIVD_W-1]};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        q    <= dividend;
        d    <= divisor;
        cnt  <= 6'(DIVD_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (rsh >= {1'b0, d}) begin
          rem <= 64'(rsh - {1'b0, d});
          q   <= {q[DIVD_W-2:0], 1'b1};
        end else begin
          rem <= rsh[63:0];
          q   <= {q[DIVD_W-2:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

endmodule

/* sv/rtd_code_to_temperature.sv */
// Channel   Dir  Word contents (lowest bit first)
// s_*       in   tdata: adc_code[14:0], zero pad
// m_*       out  tdata: temperature[18:0], zero pad; tuser: too_hot, not_converged
// wr_*      in   register write: index 0 scale, 1 iteration limit, 2 tolerance
//
// Each Newton step runs nine products through the shared 32x32 multiply
// unit and a 56-bit bit-serial divide.
// s_tready is high only while idle; one word is in flight at a time.
// A finished result waits in the output register while the next word is taken.
// rst is synchronous and restores the register reset values.
module rtd_code_to_temperature (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,   // adc_code[14:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,   // temperature[18:0]
  output logic [1:0]                       m_tuser,   // too_hot, not_converged
  input  logic                             wr_en,
  input  logic [rtdct_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rtdct_pkg::SCALE_W-1:0]    wr_data
);
  import rtdct_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_RANGE  = 8'b00000010,
    ST_ISSUE  = 8'b00000100,
    ST_WAIT   = 8'b00001000,
    ST_SQRT   = 8'b00010000,
    ST_DIVGO  = 8'b00100000,
    ST_DIV    = 8'b01000000,
    ST_FINISH = 8'b10000000
  } state_t;

  // product schedule: two for the estimate, nine for each Newton step
  typedef enum logic [3:0] {
    OP_ARG, OP_EST, OP_T2, OP_T3, OP_RA, OP_RB, OP_U, OP_RC, OP_DB, OP_V, OP_DC
  } op_t;

  state_t state;
  op_t    op;

  logic [SCALE_W-1:0] scale;
  logic [LIMIT_W-1:0] limit, lim_eff;
  logic [TOL_W-1:0]   tol;

  logic [RR_W-1:0]    rr;
  logic signed [47:0] rrm1;
  logic signed [31:0] t;
  logic [31:0]        sq;
  logic signed [63:0] t2, t3, tmp, rm1, dr60;
  logic [LIMIT_W-1:0] iter;
  logic               hot, nc, num_neg;

  mul_req_t           mreq;
  logic               mul_done;
  logic signed [63:0] mul_p;
  logic               sqrt_start, sqrt_done;
  logic [31:0]        root;
  logic               div_start, div_done;
  logic [DIVD_W-1:0]  quot, dividend;
  logic [63:0]        divisor;

  logic signed [63:0] tw, arg_c, num_c, num_mag, dr_mag, t_sum, delta, delta_mag;
  logic signed [31:0] t_clamp;
  logic               tol_met;
  logic               hot_f;
  logic signed [31:0] t_mag, t_out;

  assign s_tready = (state == ST_IDLE);
  assign lim_eff  = (limit > MAX_STEPS) ? MAX_STEPS : limit;
  assign tw       = 64'(t);

  // operand select for the shared multiply unit
  always_comb begin
    mreq.start = (state == ST_ISSUE);
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.shift = 6'd0;
    case (op)
      OP_ARG: begin
        mreq.a = FOURB_Q72; mreq.b = 64'(rrm1); mreq.shift = 6'd40;
      end
      OP_EST: begin
        mreq.a = A_Q36 - $signed({32'd0, sq}); mreq.b = K_EST; mreq.shift = 6'd20;
      end
      OP_T2: begin
        mreq.a = tw; mreq.b = tw; mreq.shift = 6'd16;
      end
      OP_T3: begin
        mreq.a = t2; mreq.b = tw; mreq.shift = 6'd16;
      end
      OP_RA: begin
        mreq.a = COEF_A_Q60; mreq.b = tw; mreq.shift = 6'd36;
      end
      OP_RB: begin
        mreq.a = COEF_B_Q60; mreq.b = t2; mreq.shift = 6'd36;
      end
      OP_U: begin
        mreq.a = tw - T100_Q16; mreq.b = t3; mreq.shift = 6'd16;
      end
      OP_RC: begin
        mreq.a = COEF_C_Q60; mreq.b = tmp; mreq.shift = 6'd36;
      end
      OP_DB: begin
        mreq.a = COEF_B_Q60; mreq.b = tw; mreq.shift = 6'd16;
      end
      OP_V: begin
        mreq.a = tw - T75_Q16; mreq.b = t2; mreq.shift = 6'd16;
      end
      OP_DC: begin
        mreq.a = COEF_C_Q60; mreq.b = tmp; mreq.shift = 6'd16;
      end
      default: begin
        mreq.a = '0;
      end
    endcase
  end

  // root argument, Newton numerator and slope, step update
  always_comb begin
    arg_c      = A2_Q72 - mul_p;
    sqrt_start = (state == ST_WAIT) && mul_done && (op == OP_ARG) && !arg_c[63];

    num_c     = 64'(rrm1) - rm1;
    num_mag   = num_c[63] ? -num_c : num_c;
    dividend  = {num_mag[43:0], 12'd0};
    dr_mag    = (dr60[63] ? -dr60 : dr60) >>> 24;
    // slope at or below zero counts as one LSB
    divisor   = (dr60[63] || dr_mag == 64'sd0) ? 64'd1 : 64'(dr_mag);
    div_start = (state == ST_DIVGO);

    t_sum = num_neg ? tw - $signed(64'(quot)) : tw + $signed(64'(quot));
    if (t_sum > T_LIMIT) begin
      t_clamp = 32'(T_LIMIT);
    end else if (t_sum < -T_LIMIT) begin
      t_clamp = 32'(-T_LIMIT);
    end else begin
      t_clamp = 32'(t_sum);
    end
    delta     = 64'(t_clamp) - tw;
    delta_mag = delta[63] ? -delta : delta;
    tol_met   = delta_mag <= $signed({40'd0, tol, 8'd0});

    // output formatting: truncate toward zero to 1/256 C, floor at -256 C
    hot_f = hot || (t > T_HOT);
    t_mag = t[31] ? -t : t;
    t_out = t[31] ? -(t_mag >>> 8) : (t_mag >>> 8);
    if (t_out < 32'(OUT_COLD)) begin
      t_out = 32'(OUT_COLD);
    end
  end

  rtdct_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .p    (mul_p)
  );

  rtdct_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .v     (arg_c[62:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  rtdct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RST;
      limit <= LIMIT_RST;
      tol   <= TOL_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SCALE: scale <= wr_data;
        REG_LIMIT: limit <= wr_data[LIMIT_W-1:0];
        REG_TOL:   tol   <= wr_data[TOL_W-1:0];
        default:   ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_ARG;
      m_tvalid <= 1'b0;
    end else begin
      // load a finished word, or drop valid once the word is taken
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            rr    <= s_tdata[ADC_W-1:0] * scale;
            hot   <= 1'b0;
            nc    <= 1'b0;
            t     <= '0;
            state <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          // anything at 8 or above saturates straight away
          if (|rr[RR_W-1:43]) begin
            hot   <= 1'b1;
            state <= ST_FINISH;
          end else begin
            rrm1  <= $signed({2'b00, rr} - 48'h100_0000_0000);
            op    <= OP_ARG;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            case (op)
              OP_ARG: begin
                if (arg_c[63]) begin
                  hot   <= 1'b1;
                  state <= ST_FINISH;
                end else begin
                  state <= ST_SQRT;
                end
              end
              OP_EST: begin
                t <= 32'(mul_p);
                if (rrm1[47] && lim_eff != '0) begin
                  iter  <= '0;
                  op    <= OP_T2;
                  state <= ST_ISSUE;
                end else begin
                  state <= ST_FINISH;
                end
              end
              OP_T2: begin
                t2 <= mul_p; op <= OP_T3; state <= ST_ISSUE;
              end
              OP_T3: begin
                t3 <= mul_p; op <= OP_RA; state <= ST_ISSUE;
              end
              OP_RA: begin
                rm1 <= mul_p; op <= OP_RB; state <= ST_ISSUE;
              end
              OP_RB: begin
                rm1 <= rm1 + mul_p; op <= OP_U; state <= ST_ISSUE;
              end
              OP_U: begin
                tmp <= mul_p; op <= OP_RC; state <= ST_ISSUE;
              end
              OP_RC: begin
                rm1 <= rm1 + mul_p; op <= OP_DB; state <= ST_ISSUE;
              end
              OP_DB: begin
                dr60 <= COEF_A_Q60 + {mul_p[62:0], 1'b0}; op <= OP_V; state <= ST_ISSUE;
              end
              OP_V: begin
                tmp <= mul_p; op <= OP_DC; state <= ST_ISSUE;
              end
              OP_DC: begin
                dr60  <= dr60 + {mul_p[61:0], 2'b00};
                state <= ST_DIVGO;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            sq    <= root;
            op    <= OP_EST;
            state <= ST_ISSUE;
          end
        end
        ST_DIVGO: begin
          num_neg <= num_c[63];
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            t <= t_clamp;
            if (tol_met) begin
              state <= ST_FINISH;
            end else if (iter == lim_eff - 7'd1) begin
              nc    <= 1'b1;
              state <= ST_FINISH;
            end else begin
              iter  <= iter + 7'd1;
              op    <= OP_T2;
              state <= ST_ISSUE;
            end
          end
        end
        ST_FINISH: begin
          // hold here until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {5'd0, hot_f ? OUT_HOT : t_out[TEMP_W-1:0]};
            m_tuser  <= {nc && !hot_f, hot_f};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/rtdct_chk.sv */
`include "rtd_code_to_temperature_macros.svh"

module rtdct_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import rtdct_pkg::*;

  `RTD_ASSERT_NOW(a_hot_sat, m_tvalid && m_tuser[0], m_tdata[18:0] == OUT_HOT && !m_tuser[1])
  `RTD_ASSERT_NOW(a_cold_floor, m_tvalid, $signed(m_tdata[18:0]) >= OUT_COLD)
  `RTD_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
  `RTD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind rtd_code_to_temperature rtdct_chk u_rtdct_chk (.*);

/* verif/rtd_code_to_temperature_test.sv */
module rtd_code_to_temperature_test;
  import rtdct_pkg::*;

  localparam int  HALF_PERIOD = 1;
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int  DRAIN_CYCLES = 400;   // no-step latency plus margin
  localparam longint Q40_ONE = longint'(1) << 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;          // adc_code[14:0], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;               // temperature[18:0], zero pad
  logic [1:0]  m_tuser;               // too_hot, not_converged
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = REG_SCALE;
  logic [SCALE_W-1:0]   wr_data = '0;

  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  longint cycles = 0;

  rtd_code_to_temperature uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    logic                     too_hot;
    logic                     not_converged;
  } reading_t;

  // Expected readings and a private copy of the calibration registers.
  class reading_scoreboard;
    reading_t   pending[$];
    bit [63:0]  scale = SCALE_RST;
    int         step_limit = LIMIT_RST;
    bit [63:0]  tolerance = TOL_RST;
    int         errors = 0;
    int         seen = 0;
    int         hot_seen = 0;
    int         nc_seen = 0;

    function bit [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // exact product, shift, truncation toward zero
    function longint mul_sh(longint a, longint b, int s);
      bit          neg;
      bit [127:0]  p;
      bit [63:0]   r;
      neg = (a < 0) != (b < 0);
      p = {64'b0, mag(a)} * {64'b0, mag(b)};
      r = 64'(p >> s);
      r[63] = 1'b0;
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint sh_tz(longint x, int s);
      bit [63:0] r;
      r = mag(x) >> s;
      r[63] = 1'b0;
      return x < 0 ? -longint'(r) : longint'(r);
    endfunction

    function bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    function reading_t convert(bit [14:0] code);
      reading_t  o;
      bit [63:0] rr, q, tol8;
      longint    rrm1, arg, sq, t, old, t2, t3, rm1, dr60, dr, num, dt;
      bit        hot, nc;
      int        lim;
      hot = 0; nc = 0; t = 0;
      rr = {49'b0, code} * scale;
      if (rr >= (64'd8 << 40)) begin
        hot = 1;
      end else begin
        rrm1 = longint'(rr) - Q40_ONE;
        arg = A2_Q72 - mul_sh(FOURB_Q72, rrm1, 40);
        if (arg < 0) begin
          hot = 1;
        end else begin
          sq = longint'(root_floor(64'(arg)));
          t = sh_tz((longint'(A_Q36) - sq) * longint'(K_EST), 20);
          if (rrm1 < 0) begin
            lim = step_limit > 64 ? 64 : step_limit;
            tol8 = tolerance << 8;
            for (int i = 0; i < lim; i++) begin
              old = t;
              t2 = mul_sh(t, t, 16);
              t3 = mul_sh(t2, t, 16);
              rm1 = mul_sh(COEF_A_Q60, t, 36) + mul_sh(COEF_B_Q60, t2, 36)
                  + mul_sh(COEF_C_Q60, mul_sh(t - longint'(T100_Q16), t3, 16), 36);
              dr60 = longint'(COEF_A_Q60) + 2 * mul_sh(COEF_B_Q60, t, 16)
                   + 4 * mul_sh(COEF_C_Q60, mul_sh(t - longint'(T75_Q16), t2, 16), 16);
              dr = sh_tz(dr60, 24);
              num = rrm1 - rm1;
              if (dr <= 0) dr = 1;
              q = (mag(num) << 12) / 64'(dr);
              dt = num < 0 ? -longint'(q) : longint'(q);
              t = old + dt;
              if (t > longint'(T_LIMIT)) t = T_LIMIT;
              if (t < -longint'(T_LIMIT)) t = -longint'(T_LIMIT);
              if (mag(t - old) <= tol8) break;
              if (i == lim - 1) nc = 1;
            end
          end
          if (t > longint'(T_HOT)) hot = 1;
        end
      end
      if (hot) begin
        t = longint'(OUT_HOT);
        nc = 0;
      end else begin
        t = sh_tz(t, 8);
        if (t < longint'(OUT_COLD)) t = OUT_COLD;
      end
      o.temperature = t[TEMP_W-1:0];
      o.too_hot = hot;
      o.not_converged = nc;
      return o;
    endfunction

    function void note(bit [14:0] code);
      pending.push_back(convert(code));
    endfunction

    task report(string what);
      $display("MISMATCH result %0d: %s", seen, what);
      errors++;
    endtask

    task check(logic signed [TEMP_W-1:0] temp, logic hot, logic nc);
      reading_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word temp=%0d", temp));
      end else begin
        e = pending.pop_front();
        if (temp !== e.temperature)
          report($sformatf("temperature %0d, want %0d", temp, e.temperature));
        if (hot !== e.too_hot)
          report($sformatf("too_hot %b, want %b", hot, e.too_hot));
        if (nc !== e.not_converged)
          report($sformatf("not_converged %b, want %b", nc, e.not_converged));
        hot_seen += e.too_hot;
        nc_seen += e.not_converged;
      end
      seen++;
    endtask
  endclass

  reading_scoreboard sb = new();

  always #HALF_PERIOD clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rtd_code_to_temperature verification failed");
      $finish;
    end
  end

  // Receiver: stall at random, check every accepted word.
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check(m_tdata[TEMP_W-1:0], m_tuser[0], m_tuser[1]);
  end

  // Drive one word; hold it until the block takes it.
  task send_code(bit [14:0] code);
    bit placed;
    placed = 0;
    while (!placed) begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, code};
        placed = 1;
      end
    end
    do @(posedge clk); while (!s_tready);
    sb.note(code);
  endtask

  // Drop valid and let every pending reading come back before touching registers.
  task drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, bit [SCALE_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_SCALE: sb.scale = val;
      REG_LIMIT: sb.step_limit = val[LIMIT_W-1:0];
      REG_TOL:   sb.tolerance = val[TOL_W-1:0];
      default:   ;
    endcase
  endtask

  task set_pressure(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  // Half the codes land below rr = 1 so the Newton path gets steady traffic.
  task run_phase(bit [30:0] scale, bit [6:0] lim, bit [15:0] tol, int n, int mode);
    longint thr;
    drain();
    write_reg(REG_SCALE, scale);
    write_reg(REG_LIMIT, 31'(lim));
    write_reg(REG_TOL, 31'(tol));
    set_pressure(mode);
    thr = (scale == 0) ? 32767 : Q40_ONE / scale;
    if (thr > 32767) thr = 32767;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1))
        send_code(15'($urandom_range(32767)));
      else
        send_code(15'($urandom_range(int'(thr))));
    end
  endtask

  initial begin
    bit [14:0] directed[$];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers: zero code, around rr = 1, full scale, alternating bits.
    directed = '{15'd0, 15'd1, 15'd2, 15'd4095, 15'd8191, 15'd8192, 15'd8193,
                 15'd16384, 15'd24576, 15'd32766, 15'd32767, 15'h5555, 15'h2AAA,
                 15'd100, 15'd1000, 15'd6000};
    foreach (directed[i]) send_code(directed[i]);

    // Largest scale: rr at 8 or above and readings above 1000 C saturate hot.
    run_phase(31'd1099511628, 7'd64, 16'd0, 12, 0);
    // Zero scale with no Newton steps at all.
    run_phase(31'd0, 7'd0, 16'd65535, 6, 0);

    run_phase(31'd134217728, 7'd20, 16'd3, 300, 0);
    run_phase(31'd1099511628, 7'd64, 16'd0, 60, 1);
    run_phase(31'd0, 7'd0, 16'd65535, 100, 2);
    // Limit above 64 acts as 64.
    run_phase(31'd134217728, 7'd127, 16'd0, 30, 3);
    for (int m = 0; m < 4; m++)
      run_phase(31'($urandom_range(1099511628)), 7'($urandom_range(12)),
                16'($urandom_range(300)), 250, m);
    run_phase(31'd200000000, 7'd1, 16'd0, 100, 1);
    run_phase(31'd134217728, 7'd1, 16'd65535, 100, 3);

    drain();
    $display("converted %0d codes over 13 register settings and 4 handshake mixes",
             sb.seen);
    $display("%0d saturated hot, %0d ran out of Newton steps", sb.hot_seen, sb.nc_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("rtd_code_to_temperature verification clean");
    else
      $display("rtd_code_to_temperature verification failed");
    $finish;
  end

endmodule
